### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, idle while reset is asserted.
`define RQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, including during reset.
`define RQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rqs_pkg.sv
`default_nettype none

package rqs_pkg;

    localparam int QDEPTH = 64;
    localparam int AW     = $clog2(QDEPTH);
    localparam int CW     = $clog2(QDEPTH + 1);

    localparam logic [2:0] KIND_PAINT = 3'd4;
    localparam logic [2:0] KIND_ASSEM = 3'd5;

    // marks bit positions
    localparam int MARK_PAINT = 0;
    localparam int MARK_ASSEM = 1;
    localparam int MARK_QA    = 2;
    localparam int MARK_PRIO  = 3;

    typedef enum logic [1:0] {
        CMD_APPEND      = 2'd0,
        CMD_REMOVE_ID   = 2'd1,
        CMD_REMOVE_HEAD = 2'd2,
        CMD_QUERY       = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] gift_id;
        logic [2:0]  gift_kind;
        logic        painting_done;
        logic        assembly_done;
        logic        qa_done;
        logic        priority_flag;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [6:0]  fill_level;
        logic        ready_found;
        logic [15:0] ready_id;
        logic [6:0]  awaiting_qa;
    } t_out_word;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  kind;
        logic [3:0]  marks;
    } t_entry;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        t_entry        data;
    } t_mem_wr;

    typedef struct packed {
        logic clr;
        logic en;
    } t_acc_ctl;

    typedef struct packed {
        logic          prio_found;
        logic [15:0]   prio_id;
        logic          other_found;
        logic [15:0]   small_id;
        logic [CW-1:0] waiting;
    } t_acc_res;

endpackage

`default_nettype wire

### hw/rtl/ready_item_queue_scheduler.sv
// Command time is set by the one read port of the entry memory, which the
//   search, shift and scan passes walk one entry a cycle.
// Throughput: one word at a time; the next is taken once the result is in the output register.
// Reset (sync, active low): queue empty, limit 64, no output pending; the
//   entry memory is not cleared and needs no clearing pass.
`default_nettype none

module ready_item_queue_scheduler (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // config
    input  wire logic               i_cfg_we,
    input  wire logic [6:0]         i_cfg_data,
    // command words
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire rqs_pkg::t_in_word  i_in_word,
    // result words
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output rqs_pkg::t_out_word      o_out_word
);
    import rqs_pkg::*;

    // Sequencer state
    t_state        r_state,   n_state;
    logic [CW-1:0] r_ptr,     n_ptr;     // next read address
    logic [CW-1:0] r_dptr,    n_dptr;    // address of data now on the read port
    logic          r_vld,     n_vld;     // read data valid
    logic [CW-1:0] r_fill,    n_fill;
    logic [6:0]    r_lim;
    logic [15:0]   r_id,      n_id;
    t_status       r_status,  n_status;
    logic          r_out_vld, n_out_vld;
    t_out_word     r_out,     n_out;

    t_mem_wr       mem_wr;
    t_entry        mem_rdata;
    t_acc_ctl      acc_ctl;
    t_acc_res      acc_res;
    t_entry        in_entry;

    logic          accept;
    logic          issue;
    logic [CW-1:0] eff_lim;
    logic [CW-1:0] wr_idx;

    rqs_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (r_ptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    rqs_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_entry (mem_rdata),
        .o_res   (acc_res)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // Limit of zero or above depth means full depth
    assign eff_lim = ((r_lim == 7'd0) || (CW'(r_lim) > CW'(QDEPTH))) ?
                     CW'(QDEPTH) : CW'(r_lim);

    assign in_entry.id    = i_in_word.gift_id;
    assign in_entry.kind  = i_in_word.gift_kind;
    assign in_entry.marks = {i_in_word.priority_flag, i_in_word.qa_done,
                             i_in_word.assembly_done, i_in_word.painting_done};

    assign issue  = r_ptr < r_fill;
    assign wr_idx = r_dptr - CW'(1);

    // accumulator is held clear outside the scan pass and the result hand-off
    assign acc_ctl.clr = (r_state != S_SCAN) && (r_state != S_DONE);
    assign acc_ctl.en  = (r_state == S_SCAN) && r_vld;

    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_dptr    = r_ptr;
        n_vld     = 1'b0;
        n_fill    = r_fill;
        n_id      = r_id;
        n_status  = r_status;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;

        mem_wr.we   = 1'b0;
        mem_wr.addr = r_fill[AW-1:0];
        mem_wr.data = in_entry;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id     = i_in_word.gift_id;
                    n_status = ST_OK;
                    n_ptr    = '0;
                    n_state  = S_SCAN;
                    unique case (i_in_word.cmd)
                        CMD_APPEND: begin
                            if (r_fill >= eff_lim) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_wr.we = 1'b1;
                                n_fill    = r_fill + CW'(1);
                            end
                        end
                        CMD_REMOVE_ID: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        CMD_REMOVE_HEAD: begin
                            if (r_fill == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_ptr   = CW'(1);
                                n_state = S_SHIFT;
                            end
                        end
                        CMD_QUERY: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end

            S_SEARCH: begin
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                    n_vld = 1'b1;
                end
                if (r_vld && (mem_rdata.id == r_id)) begin
                    // first match: close the gap from here
                    n_ptr   = r_dptr + CW'(1);
                    n_vld   = 1'b0;
                    n_state = S_SHIFT;
                end else if (!r_vld && !issue) begin
                    n_status = ST_NOT_FOUND;
                    n_ptr    = '0;
                    n_state  = S_SCAN;
                end
            end

            S_SHIFT: begin
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                    n_vld = 1'b1;
                end
                if (r_vld) begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = wr_idx[AW-1:0];
                    mem_wr.data = mem_rdata;
                end else if (!issue) begin
                    n_fill  = r_fill - CW'(1);
                    n_ptr   = '0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                if (issue) begin
                    n_ptr = r_ptr + CW'(1);
                    n_vld = 1'b1;
                end
                if (!r_vld && !issue) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld            = 1'b1;
                    n_out.status         = r_status;
                    n_out.fill_level     = r_fill;
                    n_out.ready_found    = acc_res.prio_found || acc_res.other_found;
                    n_out.ready_id       = acc_res.prio_found  ? acc_res.prio_id  :
                                           acc_res.other_found ? acc_res.small_id : 16'd0;
                    n_out.awaiting_qa    = acc_res.waiting;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_dptr    <= '0;
            r_vld     <= 1'b0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_dptr    <= n_dptr;
            r_vld     <= n_vld;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= 7'd64;
        end else if (i_cfg_we) begin
            r_lim <= i_cfg_data;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_status <= n_status;
        r_out    <= n_out;
    end

`include "assert_macros.svh"

    `RQS_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= CW'(QDEPTH), "fill above depth")
    `RQS_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_vld) |-> $past(r_state == S_DONE), "result without finished pass")
    `RQS_ASSERT(a_fill_change, i_clk, i_rst_n, !$stable(r_fill) |-> ($past(accept) || $past(r_state == S_SHIFT)), "fill moved outside append or shift")
    `RQS_ASSERT(a_shift_addr, i_clk, i_rst_n, (r_state == S_SHIFT && r_vld) |-> (r_dptr != '0 && r_dptr < r_fill), "shift write out of range")

endmodule

`default_nettype wire

### hw/rtl/rqs_mem.sv
`default_nettype none

module rqs_mem (
    input  wire logic                      i_clk,
    input  wire rqs_pkg::t_mem_wr          i_wr,
    input  wire logic [rqs_pkg::AW-1:0]    i_raddr,
    output rqs_pkg::t_entry                o_rdata
);
    import rqs_pkg::*;

    t_entry r_mem [QDEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/rqs_acc.sv
`default_nettype none

// Per-entry accumulate: waiting-QA count, first priority pick, smallest other ID.
module rqs_acc (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rqs_pkg::t_acc_ctl i_ctl,
    input  wire rqs_pkg::t_entry   i_entry,
    output rqs_pkg::t_acc_res      o_res
);
    import rqs_pkg::*;

    t_acc_res r_res;
    t_acc_res n_res;
    logic     kind_45;
    logic     elig;
    logic     smaller;

    always_comb begin
        kind_45 = (i_entry.kind == KIND_PAINT) || (i_entry.kind == KIND_ASSEM);
        elig    = i_entry.marks[MARK_QA] &&
                  (((i_entry.kind == KIND_PAINT) && i_entry.marks[MARK_PAINT]) ||
                   ((i_entry.kind == KIND_ASSEM) && i_entry.marks[MARK_ASSEM]));
        smaller = i_entry.id < r_res.small_id;

        n_res = r_res;
        if (i_ctl.clr) begin
            n_res = '0;
        end else if (i_ctl.en) begin
            if (kind_45 && !i_entry.marks[MARK_QA]) begin
                n_res.waiting = r_res.waiting + CW'(1);
            end
            if (elig) begin
                if (i_entry.marks[MARK_PRIO]) begin
                    if (!r_res.prio_found) begin
                        n_res.prio_found = 1'b1;
                        n_res.prio_id    = i_entry.id;
                    end
                end else if (!r_res.other_found || smaller) begin
                    n_res.other_found = 1'b1;
                    n_res.small_id    = i_entry.id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire
